>>> rtl/fqsr_pkg.sv
// Package with the operation and status codes of the FIFO queue with search and reverse.
package fqsr_pkg;

   // Operation codes carried in req_op.
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_SEARCH  = 2'd2;
   localparam logic [1:0] OP_REVERSE = 2'd3;

   // Status codes returned in rsp_status.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // Fixed widths of the transaction fields.
   localparam int OP_WIDTH     = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int DATA_WIDTH   = 32;
   localparam int POS_WIDTH    = 5;

   typedef logic [OP_WIDTH-1:0]     op_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;

endpackage

>>> rtl/fifo_queue_with_search_reverse_unit.sv
// Top level of the FIFO queue with search and in-place reverse, built around one ring memory.
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+--------------------------------------------
//   req_    | in        | req_valid / req_stall   | op, value
//   rsp_    | out       | rsp_valid / rsp_stall   | status, word_out, position, occupancy
//
// Enqueue and reverse register their result at the accepting edge. A dequeue reads the front word
// into the read register of the ring memory at that edge and registers its result from it in S_DEQ.
// A search ends at the first match or after the last word when the key is absent: the single read
// port delivers one entry a cycle and the compare sits behind the read register.
// Reset is synchronous and active high; it empties the queue and clears the direction bit.
// req_stall is high during a dequeue or search and while a result is held against rsp_stall.
module fifo_queue_with_search_reverse_unit
   import fqsr_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  op_type                       req_op,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output status_type                   rsp_status,
   output logic signed [DATA_WIDTH-1:0] rsp_word_out,
   output logic [POS_WIDTH-1:0]         rsp_position,
   output logic [POS_WIDTH-1:0]         rsp_occupancy
);

   // Slot index width and the width of a count that can hold DEPTH itself.
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DEQ  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   // Moves a slot index by an offset around the ring, forward or backward.
   function automatic logic [AW-1:0] ring_offset(input logic [AW-1:0] base,
                                                  input logic [AW-1:0] off,
                                                  input logic          backward);
      logic [AW:0] sum;
      if (backward) begin
         if (off > base) begin
            sum = {1'b0, base} + DEPTH_W - {1'b0, off};
         end else begin
            sum = {1'b0, base} - {1'b0, off};
         end
      end else begin
         sum = {1'b0, base} + {1'b0, off};
         if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
         end
      end
      return sum[AW-1:0];
   endfunction

   // Ring memory: one write port, one registered read port.
   logic [WORD_WIDTH-1:0] ring_mem [DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [WORD_WIDTH-1:0] wr_word;

   // Control state.
   logic [1:0]      state_ff, state_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            flip_ff, flip_in;

   // Search walk: next slot to read, reads issued so far, and the position of the word that
   // sits in the read register.
   logic [AW-1:0]         scan_ff, scan_in;
   logic [CW-1:0]         issued_ff, issued_in;
   logic [CW-1:0]         rd_pos_ff, rd_pos_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [WORD_WIDTH-1:0] key_ff, key_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0] rsp_word_ff, rsp_word_in;
   logic [POS_WIDTH-1:0]  rsp_position_ff, rsp_position_in;
   logic [POS_WIDTH-1:0]  rsp_occupancy_ff, rsp_occupancy_in;

   logic          req_fire;
   logic          queue_empty;
   logic          queue_full;
   logic [CW-1:0] count_m1;

   // A new transaction is taken only by an idle sequencer, and only if the result register
   // is free or is emptied at the same edge. Every result of a dequeue or search is therefore
   // written into a result register that is already free.
   assign req_stall   = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire    = req_valid && !req_stall;
   assign queue_empty = (count_ff == '0);
   assign queue_full  = (count_ff == DEPTH_C);
   assign count_m1    = count_ff - 1'b1;

   // The stored form of the incoming word: sign extended or truncated to WORD_WIDTH.
   assign wr_word = WORD_WIDTH'(req_value);

   always_comb begin
      state_in         = state_ff;
      head_in          = head_ff;
      count_in         = count_ff;
      flip_in          = flip_ff;
      scan_in          = scan_ff;
      issued_in        = issued_ff;
      rd_pos_in        = rd_pos_ff;
      rd_valid_in      = 1'b0;
      key_in           = key_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_status_in    = rsp_status_ff;
      rsp_word_in      = rsp_word_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_occupancy_in = rsp_occupancy_ff;
      rd_en            = 1'b0;
      rd_addr          = head_ff;
      wr_en            = 1'b0;
      wr_addr          = ring_offset(head_ff, count_ff[AW-1:0], flip_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // Defaults for a result that is produced at this edge.
               rsp_status_in   = STATUS_OK;
               rsp_word_in     = '0;
               rsp_position_in = '0;
               case (req_op)
                  OP_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (queue_full) begin
                        rsp_status_in    = STATUS_FULL;
                        rsp_occupancy_in = POS_WIDTH'(count_ff);
                     end else begin
                        // The back of the queue is the slot just past the last word.
                        wr_en            = 1'b1;
                        count_in         = count_ff + 1'b1;
                        rsp_occupancy_in = POS_WIDTH'(count_ff + 1'b1);
                     end
                  end
                  OP_DEQUEUE: begin
                     if (queue_empty) begin
                        rsp_valid_in     = 1'b1;
                        rsp_status_in    = STATUS_EMPTY;
                        rsp_occupancy_in = POS_WIDTH'(count_ff);
                     end else begin
                        // Read the front word now; it is returned from the read register
                        // in the next cycle, after the pointers have already moved.
                        rd_en    = 1'b1;
                        head_in  = ring_offset(head_ff, AW'(1), flip_ff);
                        count_in = count_m1;
                        state_in = S_DEQ;
                     end
                  end
                  OP_SEARCH: begin
                     if (queue_empty) begin
                        rsp_valid_in     = 1'b1;
                        rsp_status_in    = STATUS_EMPTY;
                        rsp_occupancy_in = POS_WIDTH'(count_ff);
                     end else begin
                        // The first read goes out at the accepting edge.
                        rd_en       = 1'b1;
                        rd_valid_in = 1'b1;
                        rd_pos_in   = CW'(1);
                        issued_in   = CW'(1);
                        scan_in     = ring_offset(head_ff, AW'(1), flip_ff);
                        key_in      = wr_word;
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in     = 1'b1;
                     rsp_occupancy_in = POS_WIDTH'(count_ff);
                     if (queue_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        // The old back word becomes the front and the walk direction turns.
                        head_in = ring_offset(head_ff, count_m1[AW-1:0], flip_ff);
                        flip_in = !flip_ff;
                     end
                  end
               endcase
            end
         end
         S_DEQ: begin
            rsp_valid_in     = 1'b1;
            rsp_status_in    = STATUS_OK;
            rsp_word_in      = DATA_WIDTH'(rd_data_ff);
            rsp_position_in  = '0;
            rsp_occupancy_in = POS_WIDTH'(count_ff);
            state_in         = S_IDLE;
         end
         S_SCAN: begin
            // Issue the next read while the previous word is compared.
            if (issued_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = scan_ff;
               rd_valid_in = 1'b1;
               rd_pos_in   = issued_ff + 1'b1;
               issued_in   = issued_ff + 1'b1;
               scan_in     = ring_offset(scan_ff, AW'(1), flip_ff);
            end
            if (rd_valid_ff) begin
               if (rd_data_ff == key_ff) begin
                  rsp_valid_in     = 1'b1;
                  rsp_status_in    = STATUS_OK;
                  rsp_word_in      = '0;
                  rsp_position_in  = POS_WIDTH'(rd_pos_ff);
                  rsp_occupancy_in = POS_WIDTH'(count_ff);
                  rd_valid_in      = 1'b0;
                  state_in         = S_IDLE;
               end else if (rd_pos_ff == count_ff) begin
                  rsp_valid_in     = 1'b1;
                  rsp_status_in    = STATUS_NOT_FOUND;
                  rsp_word_in      = '0;
                  rsp_position_in  = '0;
                  rsp_occupancy_in = POS_WIDTH'(count_ff);
                  state_in         = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Writes happen only for an accepted enqueue and reads only for dequeue and search, so a
   // read never meets a write to the same slot at the same edge, and a read in the cycle after a
   // write already sees the new word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_word;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         flip_ff      <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         flip_ff      <= flip_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff          <= scan_in;
      issued_ff        <= issued_in;
      rd_pos_ff        <= rd_pos_in;
      key_ff           <= key_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_word_ff      <= rsp_word_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_word_out  = rsp_word_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

endmodule

>>> rtl/fqsr_checker.sv
// Port-level checker for the FIFO queue with search and reverse, with its bind statement.
module fqsr_checker
   import fqsr_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input op_type                       req_op,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input status_type                   rsp_status,
   input logic signed [DATA_WIDTH-1:0] rsp_word_out,
   input logic [POS_WIDTH-1:0]         rsp_position,
   input logic [POS_WIDTH-1:0]         rsp_occupancy
);

   // A result held against stall keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_word_out)
         && $stable(rsp_position) && $stable(rsp_occupancy))
      else $error("result changed while stalled");

   // Only a successful transaction carries a word or a position.
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_word_out == '0) && (rsp_position == '0))
      else $error("failed transaction carries a word or a position");

   // An empty status means the queue holds nothing.
   a_empty_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty status with nonzero occupancy");

   // Enqueue and reverse answer at the edge that accepts them.
   a_single_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && ((req_op == OP_ENQUEUE) || (req_op == OP_REVERSE))
         |=> rsp_valid)
      else $error("enqueue or reverse result missing");

   // No result leaves the block right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fifo_queue_with_search_reverse_unit fqsr_checker u_fqsr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_op        (req_op),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_word_out  (rsp_word_out),
   .rsp_position  (rsp_position),
   .rsp_occupancy (rsp_occupancy)
);

>>> tb/sv/fifo_queue_with_search_reverse_unit_tb.sv
// Self-checking testbench for the FIFO queue with search and in-place reverse.
module fifo_queue_with_search_reverse_unit_tb;
   import fqsr_pkg::*;

   localparam int DEPTH     = 16;
   localparam int HOLD_LEN  = 120;
   localparam int END_DRAIN = 40;

   // One result transaction as it appears on the rsp_ ports.
   typedef struct {
      status_type                   status;
      logic signed [DATA_WIDTH-1:0] word_out;
      logic [POS_WIDTH-1:0]         position;
      logic [POS_WIDTH-1:0]         occupancy;
   } queue_rsp_type;

   // One row of the directed table. A row is issued reps times, with the value
   // stepped by one each time. Only rows marked typed carry a hand-written result.
   typedef struct {
      op_type                       op;
      logic signed [DATA_WIDTH-1:0] value;
      int                           reps;
      bit                           typed;
      queue_rsp_type                rsp;
   } stim_row_type;

   // Bias of the random operation mix; the phase is picked anew every 48 items.
   typedef enum {PH_FILL, PH_DRAIN, PH_MIX} mix_phase_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   op_type                       req_op = OP_ENQUEUE;
   logic signed [DATA_WIDTH-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   status_type                   rsp_status;
   logic signed [DATA_WIDTH-1:0] rsp_word_out;
   logic [POS_WIDTH-1:0]         rsp_position;
   logic [POS_WIDTH-1:0]         rsp_occupancy;

   // Private copy of the queue state used to work out every expected result.
   logic signed [DATA_WIDTH-1:0] model_ring [DEPTH];
   int                           model_head  = 0;
   int                           model_count = 0;
   bit                           model_flip  = 1'b0;

   // Results predicted for accepted items, oldest first.
   queue_rsp_type awaited_rsp [$];

   int  mismatches = 0;
   int  status_seen [4] = '{0, 0, 0, 0};
   int  items_sent = 0;
   bit  quiet = 1'b0;      // no idling on either side while set
   int  hold_asks = 0;     // bumped by the sender to request one long receiver hold-off
   int  hold_seen = 0;
   int  hold_left = 0;

   fifo_queue_with_search_reverse_unit #(
      .DEPTH(DEPTH),
      .WORD_WIDTH(DATA_WIDTH)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_word_out (rsp_word_out),
      .rsp_position (rsp_position),
      .rsp_occupancy(rsp_occupancy)
   );

   always #1 clock = ~clock;

   // Physical slot of logical entry i, counted from the front. When the order has been
   // flipped the queue runs downward through the ring from the head.
   function automatic int ring_slot(int i);
      if (model_flip)
         return (model_head + DEPTH - (i % DEPTH)) % DEPTH;
      return (model_head + i) % DEPTH;
   endfunction

   // Applies one operation to the private queue copy and returns the result it causes.
   function automatic queue_rsp_type predict_queue_op(op_type op,
                                                      logic signed [DATA_WIDTH-1:0] value);
      queue_rsp_type r;
      bit            found;
      int            k;
      r.status   = STATUS_OK;
      r.word_out = '0;
      r.position = '0;
      found      = 1'b0;
      case (op)
         OP_ENQUEUE: begin
            // A full queue drops the word and leaves every pointer alone.
            if (model_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               model_ring[ring_slot(model_count)] = value;
               model_count++;
            end
         end
         OP_DEQUEUE: begin
            if (model_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.word_out = model_ring[model_head];
               model_head = ring_slot(1);
               model_count--;
            end
         end
         OP_SEARCH: begin
            if (model_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               // The first match from the front wins, so duplicates matter here.
               r.status = STATUS_NOT_FOUND;
               for (k = 0; k < model_count && !found; k++) begin
                  if (model_ring[ring_slot(k)] == value) begin
                     found      = 1'b1;
                     r.status   = STATUS_OK;
                     r.position = POS_WIDTH'(k + 1);
                  end
               end
            end
         end
         OP_REVERSE: begin
            // The head moves to the old back entry and the direction bit toggles; no word
            // moves. With one word this has no visible effect but the bit still changes.
            if (model_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               model_head = ring_slot(model_count - 1);
               model_flip = ~model_flip;
            end
         end
      endcase
      r.occupancy = POS_WIDTH'(model_count);
      return r;
   endfunction

   // Data value with a bias toward the extremes and toward a small pool that makes
   // duplicate entries, so a search has to find the first of several matches.
   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      if (r <= 4)
         return DATA_WIDTH'($urandom_range(0, 7)) - 3;
      return $urandom;
   endfunction

   // Search key: mostly a word that is queued right now, otherwise an arbitrary value.
   function automatic logic signed [DATA_WIDTH-1:0] pick_key();
      if (model_count > 0 && $urandom_range(0, 99) < 65)
         return model_ring[ring_slot($urandom_range(0, model_count - 1))];
      return pick_value();
   endfunction

   function automatic op_type pick_op(mix_phase_type phase);
      int r;
      r = $urandom_range(0, 99);
      case (phase)
         PH_FILL:  return (r < 55) ? OP_ENQUEUE : (r < 75) ? OP_SEARCH :
                          (r < 90) ? OP_DEQUEUE : OP_REVERSE;
         PH_DRAIN: return (r < 15) ? OP_ENQUEUE : (r < 35) ? OP_SEARCH :
                          (r < 85) ? OP_DEQUEUE : OP_REVERSE;
         default:  return (r < 35) ? OP_ENQUEUE : (r < 60) ? OP_SEARCH :
                          (r < 85) ? OP_DEQUEUE : OP_REVERSE;
      endcase
   endfunction

   // Offers one transaction, records its expected result and waits until it is taken.
   // Valid stays high into the next item unless the sender chooses to idle, so it is
   // never lowered and raised in the same time step.
   task automatic send_op(input op_type op, input logic signed [DATA_WIDTH-1:0] value,
                          input bit typed, input queue_rsp_type typed_rsp);
      queue_rsp_type pred;
      pred = predict_queue_op(op, value);
      awaited_rsp.push_back(typed ? typed_rsp : pred);
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do
         @(posedge clock);
      while (req_stall);
      items_sent++;
      if (!quiet && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Receiver side: random stalls, a long hold-off on request and none in the quiet stretch.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_LEN - 1;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 26);
      end
   end

   // Every result taken from the block is compared with the oldest expectation.
   always @(posedge clock) begin
      queue_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result status %0d word %0d pos %0d occ %0d", $time,
                     rsp_status, rsp_word_out, rsp_position, rsp_occupancy);
         end else begin
            want = awaited_rsp.pop_front();
            status_seen[rsp_status]++;
            if (rsp_status !== want.status || rsp_word_out !== want.word_out ||
                rsp_position !== want.position || rsp_occupancy !== want.occupancy) begin
               mismatches++;
               $display("%0t: expected status %0d word %0d pos %0d occ %0d, got %0d %0d %0d %0d",
                        $time, want.status, want.word_out, want.position, want.occupancy,
                        rsp_status, rsp_word_out, rsp_position, rsp_occupancy);
            end
         end
      end
   end

   // Stimulus: the directed table first, then phased random traffic.
   initial begin
      stim_row_type  rows [$];
      queue_rsp_type none;
      mix_phase_type phase;
      op_type        op;
      int            n;
      int            k;
      none.status    = STATUS_OK;
      none.word_out  = '0;
      none.position  = '0;
      none.occupancy = '0;
      phase          = PH_FILL;

      // Empty queue: every operation but enqueue reports empty.
      rows.push_back('{OP_DEQUEUE, 0,  1, 1, '{STATUS_EMPTY, 0, 0, 0}});
      rows.push_back('{OP_SEARCH,  -1, 1, 1, '{STATUS_EMPTY, 0, 0, 0}});
      rows.push_back('{OP_REVERSE, 0,  1, 1, '{STATUS_EMPTY, 0, 0, 0}});
      // Extreme words, and a reverse with a single word queued.
      rows.push_back('{OP_ENQUEUE, 32'h7FFF_FFFF, 1, 1, '{STATUS_OK, 0, 0, 1}});
      rows.push_back('{OP_REVERSE, 0,             1, 1, '{STATUS_OK, 0, 0, 1}});
      rows.push_back('{OP_ENQUEUE, 32'h8000_0000, 1, 1, '{STATUS_OK, 0, 0, 2}});
      rows.push_back('{OP_SEARCH,  32'h8000_0000, 1, 1, '{STATUS_OK, 0, 2, 2}});
      rows.push_back('{OP_DEQUEUE, 0, 1, 1, '{STATUS_OK, 32'h7FFF_FFFF, 0, 1}});
      rows.push_back('{OP_DEQUEUE, 0, 1, 1, '{STATUS_OK, 32'h8000_0000, 0, 0}});
      // Fill to the brim, then overflow, search both ends, miss, reverse, search again and dequeue.
      rows.push_back('{OP_ENQUEUE, 100, DEPTH, 0, none});
      rows.push_back('{OP_ENQUEUE, -5,  1, 1, '{STATUS_FULL, 0, 0, POS_WIDTH'(DEPTH)}});
      rows.push_back('{OP_SEARCH,  115, 1, 0, none});
      rows.push_back('{OP_SEARCH,  100, 1, 0, none});
      rows.push_back('{OP_SEARCH,  0,   1, 1, '{STATUS_NOT_FOUND, 0, 0, POS_WIDTH'(DEPTH)}});
      rows.push_back('{OP_REVERSE, 0,   1, 0, none});
      rows.push_back('{OP_SEARCH,  100, 1, 0, none});
      rows.push_back('{OP_DEQUEUE, 0,   1, 0, none});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         for (k = 0; k < rows[i].reps; k++)
            send_op(rows[i].op, rows[i].value + k, rows[i].typed, rows[i].rsp);
      end

      // Random part. The receiver hold-off fills the block while items keep coming; the
      // pause lets every outstanding result drain before traffic resumes.
      for (n = 0; n < 1820; n++) begin
         if (n % 48 == 0)
            phase = mix_phase_type'($urandom_range(0, 2));
         if (n == 300)
            hold_asks <= hold_asks + 1;
         if (n == 600) begin
            req_valid <= 1'b0;
            while (awaited_rsp.size() != 0) @(posedge clock);
            @(posedge clock);
         end
         if (n == 900)
            quiet <= 1'b1;
         if (n == 1150)
            quiet <= 1'b0;
         op = pick_op(phase);
         send_op(op, (op == OP_SEARCH) ? pick_key() : pick_value(), 1'b0, none);
      end

      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (END_DRAIN) @(posedge clock);

      $display("%0d transactions checked: %0d ok, %0d empty, %0d full, %0d key not found",
               items_sent, status_seen[STATUS_OK], status_seen[STATUS_EMPTY],
               status_seen[STATUS_FULL], status_seen[STATUS_NOT_FOUND]);
      $display("phased fill and drain traffic, one long receiver hold-off, one full drain pause");
      if (mismatches == 0)
         $display("fifo_queue_with_search_reverse_unit: match");
      else
         $display("fifo_queue_with_search_reverse_unit: mismatch");
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #600000;
      $display("%0t: timeout with %0d results outstanding", $time, awaited_rsp.size());
      $display("fifo_queue_with_search_reverse_unit: mismatch");
      $finish;
   end

endmodule
